FILE: hw/rtl/mtrc_pkg.sv
// Shared types, constants and codes for the Modbus TCP response checker.
// No dependencies.
package mtrc_pkg;

  localparam int unsigned MaxFrameBytesDef = 260;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_WSGL  = 2'd1;
  localparam logic [1:0] KIND_WMUL  = 2'd2;

  localparam logic [7:0] FC_READ_HOLDING   = 8'h03;
  localparam logic [7:0] FC_WRITE_SINGLE   = 8'h06;
  localparam logic [7:0] FC_WRITE_MULTIPLE = 8'h10;
  localparam logic [7:0] EXC_BIT           = 8'h80;
  localparam logic [15:0] ANY_REGISTER     = 16'hFFFF;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_LENGTH = 3'd1;
  localparam logic [2:0] ST_PROTO  = 3'd2;
  localparam logic [2:0] ST_DATA   = 3'd3;
  localparam logic [2:0] ST_EXC    = 3'd4;
  localparam logic [2:0] ST_FUNC   = 3'd5;

  localparam logic [2:0] REG_KIND  = 3'd0;
  localparam logic [2:0] REG_TRANS = 3'd1;
  localparam logic [2:0] REG_UNIT  = 3'd2;
  localparam logic [2:0] REG_QTY   = 3'd3;
  localparam logic [2:0] REG_REG   = 3'd4;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] txn_id;
    logic [7:0]  unit_id;
    logic [6:0]  quantity;
    logic [15:0] register_addr;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] word;
    logic [15:0] extra_word;
    logic [6:0]  word_index;
    logic        is_final;
  } result_t;

endpackage

FILE: hw/rtl/modbus_tcp_response_checker.sv
// A result is registered in the result queue; it reaches the output once the results ahead of it are read.
// Throughput: one byte per cycle; the front takes a byte whenever the
// two-entry result queue has room, so output stalls back up after two results.
// Reset (rst_n, synchronous): frame state cleared, queue emptied, registers
// return to kind 0, ids 0, quantity 0, expected register 0xFFFF.
// Depends on mtrc_pkg, mtrc_front and mtrc_fifo.
module modbus_tcp_response_checker #(
  parameter int unsigned MAX_FRAME_BYTES = mtrc_pkg::MaxFrameBytesDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [15:0] out_word,
  output logic [15:0] out_extra_word,
  output logic [6:0]  out_word_index,
  output logic        out_is_final,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import mtrc_pkg::*;

  cfg_t    cfg_r;
  result_t fr_res, q_res;
  logic    fr_valid, q_full, q_valid;
  logic [2:0] reg_idx;

  assign cfg_pready = 1'b1;
  assign reg_idx = cfg_paddr[4:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kind <= KIND_READ;
      cfg_r.txn_id <= '0;
      cfg_r.unit_id <= '0;
      cfg_r.quantity <= '0;
      cfg_r.register_addr <= ANY_REGISTER;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      case (reg_idx)
        REG_KIND:  cfg_r.kind <= cfg_pwdata[1:0];
        REG_TRANS: cfg_r.txn_id <= cfg_pwdata[15:0];
        REG_UNIT:  cfg_r.unit_id <= cfg_pwdata[7:0];
        REG_QTY:   cfg_r.quantity <= cfg_pwdata[6:0];
        REG_REG:   cfg_r.register_addr <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KIND:  cfg_prdata = {30'd0, cfg_r.kind};
      REG_TRANS: cfg_prdata = {16'd0, cfg_r.txn_id};
      REG_UNIT:  cfg_prdata = {24'd0, cfg_r.unit_id};
      REG_QTY:   cfg_prdata = {25'd0, cfg_r.quantity};
      REG_REG:   cfg_prdata = {16'd0, cfg_r.register_addr};
      default:   cfg_prdata = 32'd0;
    endcase
  end

  assign in_ready = !q_full;

  mtrc_front #(.MAX_FRAME_BYTES(MAX_FRAME_BYTES)) u_front (
    .clk, .rst_n, .cfg(cfg_r),
    .byte_valid(in_valid && in_ready),
    .rx_byte(in_rx_byte), .frame_end(in_frame_end),
    .res_valid(fr_valid), .res(fr_res)
  );

  mtrc_fifo u_fifo (
    .clk, .rst_n, .wr_en(fr_valid), .wr_data(fr_res), .full(q_full),
    .rd_valid(q_valid), .rd_en(q_valid && out_ready), .rd_data(q_res)
  );

  assign out_valid      = q_valid;
  assign out_status     = q_res.status;
  assign out_word       = q_res.word;
  assign out_extra_word = q_res.extra_word;
  assign out_word_index = q_res.word_index;
  assign out_is_final   = q_res.is_final;
endmodule

FILE: hw/rtl/mtrc_front.sv
// Front part: captures MBAP header fields per byte and classifies each byte
// into a streamed word, a final verdict or nothing. Depends on mtrc_pkg.
module mtrc_front #(
  parameter int unsigned MAX_FRAME_BYTES = mtrc_pkg::MaxFrameBytesDef
) (
  input  logic              clk,
  input  logic              rst_n,
  input  mtrc_pkg::cfg_t    cfg,
  input  logic              byte_valid,
  input  logic [7:0]        rx_byte,
  input  logic              frame_end,
  output logic              res_valid,
  output mtrc_pkg::result_t res
);
  import mtrc_pkg::*;

  localparam int PW = $clog2(MAX_FRAME_BYTES + 2);
  localparam logic [PW-1:0] MAXP = PW'(MAX_FRAME_BYTES);

  logic [PW-1:0] pos_r, pos_nxt;
  logic [15:0] tid_r, tid_nxt, hlen_r, hlen_nxt, addr_r, addr_nxt;
  logic        pnz_r, pnz_nxt;
  logic [7:0]  uid_r, uid_nxt, fc_r, fc_nxt, dbc_r, dbc_nxt, pend_r, pend_nxt;
  logic [6:0]  we_r, we_nxt;

  logic        captured, pair_done;
  logic [PW-1:0] p, len;
  logic [15:0] pair;
  logic [7:0]  base;
  logic        base_bad;
  logic [15:0] len_m6, hl_p1;

  always_comb begin
    pos_nxt = pos_r; tid_nxt = tid_r; pnz_nxt = pnz_r; hlen_nxt = hlen_r;
    uid_nxt = uid_r; fc_nxt = fc_r; dbc_nxt = dbc_r; addr_nxt = addr_r;
    pend_nxt = pend_r; we_nxt = we_r;
    captured = 1'b0; pair_done = 1'b0;
    p = pos_r;
    pair = {pend_r, rx_byte};
    res_valid = 1'b0;
    res = '0;
    base = 8'h00; base_bad = 1'b0;
    len = pos_r;
    len_m6 = '0; hl_p1 = '0;
    if (byte_valid) begin
      if (pos_r <= MAXP) begin
        pos_nxt = pos_r + 1'b1;
        captured = pos_r < MAXP;
      end
      len = pos_nxt;
      if (captured) begin
        if (p == PW'(0) || p == PW'(1)) tid_nxt = {tid_r[7:0], rx_byte};
        if ((p == PW'(2) || p == PW'(3)) && rx_byte != 8'd0) pnz_nxt = 1'b1;
        if (p == PW'(4) || p == PW'(5)) hlen_nxt = {hlen_r[7:0], rx_byte};
        if (p == PW'(6)) uid_nxt = rx_byte;
        if (p == PW'(7)) fc_nxt = rx_byte;
        if (p == PW'(8)) begin
          dbc_nxt = rx_byte; addr_nxt = {8'd0, rx_byte};
        end
        if (p == PW'(9)) addr_nxt = {addr_r[7:0], rx_byte};
        // Word pairs complete at positions 10, 12, 14 and so on.
        pair_done = (p >= PW'(10)) && !p[0];
        pend_nxt = rx_byte;
      end
      if (!frame_end) begin
        if (captured && cfg.kind == KIND_READ && pair_done) begin
          res_valid = 1'b1;
          res.word = pair;
          res.word_index = we_r;
          we_nxt = we_r + 7'd1;
        end
      end else begin
        res_valid = 1'b1;
        res.is_final = 1'b1;
        case (cfg.kind)
          KIND_READ: base = FC_READ_HOLDING;
          KIND_WSGL: base = FC_WRITE_SINGLE;
          KIND_WMUL: base = FC_WRITE_MULTIPLE;
          default:   base_bad = 1'b1;
        endcase
        len_m6 = 16'(len) - 16'd6;
        hl_p1 = hlen_nxt + 16'd1;
        if (len < PW'(8) || len > MAXP) res.status = ST_LENGTH;
        else if (pnz_nxt) res.status = ST_PROTO;
        else if (len_m6 != hl_p1) res.status = ST_LENGTH;
        else if (cfg.txn_id != 16'd0 && tid_nxt != cfg.txn_id) res.status = ST_DATA;
        else if (cfg.unit_id != 8'd0 && uid_nxt != cfg.unit_id) res.status = ST_DATA;
        else if (base_bad) res.status = ST_FUNC;
        else if (fc_nxt == (base | EXC_BIT)) res.status = ST_EXC;
        else if (fc_nxt != base) res.status = ST_FUNC;
        else if (cfg.kind == KIND_READ) begin
          if (16'(len) != 16'd9 + {8'd0, dbc_nxt}) res.status = ST_LENGTH;
          else if (dbc_nxt[0]) res.status = ST_DATA;
          else if (cfg.quantity != 7'd0 && dbc_nxt != {cfg.quantity, 1'b0})
            res.status = ST_DATA;
          else begin
            res.word = (captured && pair_done) ? pair : 16'd0;
            res.word_index = dbc_nxt[7:1];
          end
        end else if (len != PW'(12)) res.status = ST_LENGTH;
        else if (cfg.kind == KIND_WSGL) begin
          if (cfg.register_addr != ANY_REGISTER && addr_nxt != cfg.register_addr)
            res.status = ST_DATA;
          else res.word = pair;
        end else begin
          res.word = addr_nxt;
          res.extra_word = pair;
        end
        pos_nxt = '0; tid_nxt = '0; pnz_nxt = 1'b0; hlen_nxt = '0; uid_nxt = '0;
        fc_nxt = '0; dbc_nxt = '0; addr_nxt = '0; pend_nxt = '0; we_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0; tid_r <= '0; pnz_r <= 1'b0; hlen_r <= '0; uid_r <= '0;
      fc_r <= '0; dbc_r <= '0; addr_r <= '0; pend_r <= '0; we_r <= '0;
    end else begin
      pos_r <= pos_nxt; tid_r <= tid_nxt; pnz_r <= pnz_nxt; hlen_r <= hlen_nxt;
      uid_r <= uid_nxt; fc_r <= fc_nxt; dbc_r <= dbc_nxt; addr_r <= addr_nxt;
      pend_r <= pend_nxt; we_r <= we_nxt;
    end
  end
endmodule

FILE: hw/rtl/mtrc_fifo.sv
// Two-entry result queue between the front part and the output.
// Depends on mtrc_pkg.
module mtrc_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  mtrc_pkg::result_t wr_data,
  output logic              full,
  output logic              rd_valid,
  input  logic              rd_en,
  output mtrc_pkg::result_t rd_data
);
  import mtrc_pkg::*;

  result_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full = cnt_r == 2'd2;
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule

FILE: hw/rtl/mtrc_checker.sv
// Port-level checks for the Modbus TCP response checker, bound to the top.
// Depends only on the top level's ports.
module mtrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [15:0] out_word,
  input logic [15:0] out_extra_word,
  input logic [6:0]  out_word_index,
  input logic        out_is_final,
  input logic        cfg_pready
);
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= 3'd5) else $error("status out of range");
  a_stream_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_is_final) |-> (out_status == 3'd0 && out_extra_word == 16'd0))
    else $error("streamed word carries status");
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_is_final && out_status != 3'd0) |->
      (out_word == 16'd0 && out_extra_word == 16'd0 && out_word_index == 7'd0))
    else $error("failed verdict carries data");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
    else $error("result dropped while stalled");
  a_pready: assert property (@(posedge clk) cfg_pready) else $error("pready low");
endmodule

bind modbus_tcp_response_checker mtrc_checker u_mtrc_checker (.*);
